FILE: rtl/core/sortpq_pkg.sv
// Shared types and codes for the sorted priority queue core.
// No dependencies; imported by the controller, datapath and top level.
package sortpq_pkg;

    // Operation kind carried on the input channel.
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_REMOVED  = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // Command from the controller to the datapath.
    typedef enum logic [1:0] {
        OP_IDLE   = 2'd0,
        OP_REJECT = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [7:0] prio;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

FILE: rtl/core/sortpq_ctrl.sv
// Controller for the sorted priority queue: handshakes and command decode.
// Depends on sortpq_pkg.
module sortpq_ctrl
    import sortpq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_item_data,
    input  logic [7:0] s_item_priority,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    input  dp_stat_t   dp_stat,
    output cmd_t       cmd
);

    typedef enum logic {
        CS_IDLE,
        CS_HOLD
    } state_t;

    state_t  state_reg;
    status_t status_reg;
    status_t status_next;
    logic    accept;

    // A new item may enter whenever the result register is free or being drained.
    assign s_ready = (state_reg == CS_IDLE) || m_ready;
    assign accept  = s_valid && s_ready;

    // Decode the accepted item against the queue's full and empty flags.
    always_comb begin
        cmd.data    = s_item_data;
        cmd.prio    = s_item_priority;
        cmd.op      = OP_IDLE;
        status_next = STAT_INSERTED;
        if (accept) begin
            if (s_kind == KIND_DEQ) begin
                if (dp_stat.empty) begin
                    cmd.op      = OP_REJECT;
                    status_next = STAT_EMPTY;
                end else begin
                    cmd.op      = OP_REMOVE;
                    status_next = STAT_REMOVED;
                end
            end else begin
                if (dp_stat.full) begin
                    cmd.op      = OP_REJECT;
                    status_next = STAT_FULL;
                end else begin
                    cmd.op      = OP_INSERT;
                    status_next = STAT_INSERTED;
                end
            end
        end
    end

    // State and registered result status.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= CS_IDLE;
            status_reg <= STAT_INSERTED;
        end else begin
            case (state_reg)
                CS_IDLE: begin
                    if (accept) begin
                        state_reg  <= CS_HOLD;
                        status_reg <= status_next;
                    end
                end
                CS_HOLD: begin
                    if (accept) begin
                        status_reg <= status_next;
                    end else if (m_ready) begin
                        state_reg <= CS_IDLE;
                    end
                end
                default: begin
                    state_reg <= CS_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = (state_reg == CS_HOLD);
    assign m_status = status_reg;

endmodule

FILE: rtl/core/sortpq_datapath.sv
// Datapath for the sorted priority queue: a row of sorted entry cells and the count.
// Depends on sortpq_pkg.
module sortpq_datapath
    import sortpq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    output dp_stat_t   dp_stat,
    output logic [7:0] out_data,
    output logic [4:0] occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    data_reg [DEPTH];
    logic [7:0]    prio_reg [DEPTH];
    logic [7:0]    data_next [DEPTH];
    logic [7:0]    prio_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    out_data_reg;
    logic [DEPTH-1:0] gt;
    logic [CW+4:0] count_ext;

    // Held cells whose priority is strictly above the new one; the row is sorted,
    // so these form a contiguous tail of the held region.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = (CW'(i) < count_reg) && (prio_reg[i] > cmd.prio);
        end
    end

    // Per-cell next value: insert shifts the tail back, remove shifts all forward.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            data_next[i] = data_reg[i];
            prio_next[i] = prio_reg[i];
            if (cmd.op == OP_INSERT) begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                    data_next[i] = data_reg[(i > 0) ? i - 1 : 0];
                    prio_next[i] = prio_reg[(i > 0) ? i - 1 : 0];
                end else if (gt[i] || (CW'(i) == count_reg)) begin
                    data_next[i] = cmd.data;
                    prio_next[i] = cmd.prio;
                end
            end else if (cmd.op == OP_REMOVE) begin
                if (i < DEPTH - 1) begin
                    data_next[i] = data_reg[(i < DEPTH - 1) ? i + 1 : i];
                    prio_next[i] = prio_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    // Entry count follows the executed operation.
    always_comb begin
        case (cmd.op)
            OP_INSERT: count_next = count_reg + 1'b1;
            OP_REMOVE: count_next = count_reg - 1'b1;
            default:   count_next = count_reg;
        endcase
    end

    // Cell row and removed-data register.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            data_reg[i] <= data_next[i];
            prio_reg[i] <= prio_next[i];
        end
        if (cmd.op != OP_IDLE) begin
            out_data_reg <= (cmd.op == OP_REMOVE) ? data_reg[0] : 8'd0;
        end
    end

    // Count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign dp_stat.full  = (count_reg == CW'(DEPTH));
    assign dp_stat.empty = (count_reg == '0);
    assign out_data      = out_data_reg;
    assign count_ext     = {5'd0, count_reg};
    assign occupancy     = count_ext[4:0];

endmodule

FILE: rtl/core/sorted_priority_queue_core.sv
// Sorted priority queue core: stable, lowest priority number served first.
// Latency: the result is presented the cycle after the item transfer. One item per cycle
// while m_ready is high; an insert or remove updates the whole cell row at once.
// Reset clears the entry count and any pending result; cell contents are not cleared.
// Depends on sortpq_pkg, sortpq_ctrl and sortpq_datapath.
module sorted_priority_queue_core
    import sortpq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_item_data,
    input  logic [7:0] s_item_priority,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_out_data,
    output logic [4:0] m_occupancy
);

    cmd_t     cmd;
    dp_stat_t dp_stat;

    // Handshake control and command decode.
    sortpq_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_item_data     (s_item_data),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .dp_stat         (dp_stat),
        .cmd             (cmd)
    );

    // Sorted entry storage.
    sortpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .dp_stat   (dp_stat),
        .out_data  (m_out_data),
        .occupancy (m_occupancy)
    );

endmodule
